// ===== rtl/apt_pkg.sv =====
package apt_pkg;

   localparam int MaxEntries = 64;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int LenW = $clog2(MaxEntries + 1);

   localparam logic [3:0] CMD_ADD        = 4'd0;
   localparam logic [3:0] CMD_REMOVE_AT  = 4'd1;
   localparam logic [3:0] CMD_SET        = 4'd2;
   localparam logic [3:0] CMD_SET_EXPAND = 4'd3;
   localparam logic [3:0] CMD_GET        = 4'd4;
   localparam logic [3:0] CMD_FIND_ADDR  = 4'd5;
   localparam logic [3:0] CMD_FIND_OBJ   = 4'd6;
   localparam logic [3:0] CMD_DEL_ADDR   = 4'd7;
   localparam logic [3:0] CMD_DEL_OBJ    = 4'd8;
   localparam logic [3:0] CMD_HAS_PAIR   = 4'd9;
   localparam logic [3:0] CMD_TRUNCATE   = 4'd10;
   localparam logic [3:0] CMD_CLEAR      = 4'd11;
   localparam logic [3:0] CMD_SIZE       = 4'd12;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [0:0] REG_MAX_ADDR = 1'b0;
   localparam logic [0:0] REG_MAX_OBJ  = 1'b1;

   // Controller to datapath.
   typedef struct packed {
      logic       load;      // capture the request
      logic       scan_clr;  // rp to zero, wp to zero or len, counters cleared
      logic       scan_step; // consume one read entry
      logic       rd_issue;  // issue a read at the read pointer
      logic       fill_step; // write one gap entry of set_expand
      logic       finish;    // apply the command's length and result
      logic       emit_find; // present one find result
   } apt_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [3:0] cmd;
      logic       rd_done;    // read pointer reached the length
      logic       fill_done;  // gap fill complete
      logic       match;      // read entry matches the key
      logic       matches_left; // more find matches still to emit
   } apt_stat_type;

endpackage

// ===== rtl/association_pair_table.sv =====
// Channel   | Handshake                      | Word
// ----------+--------------------------------+---------------------------------------------
// request   | req_valid / req_ready          | cmd, index, address_index, group_object, ...
// response  | rsp_valid / rsp_ready          | status, address_out, group_object_out, ...
// csr       | csr psel/penable/pwrite, pready| max address index, max group object
//
// One command is handled at a time; a word is taken only in idle. Set, truncate,
// clear, size and unknown codes go from the start state straight to finish. Walks
// (add, remove, deletes, has_pair) read each stored entry in turn; get rereads its own
// entry; set_expand writes its gap entries before it finishes. A find with matches walks
// the table twice, the second pass emitting one word per match. A walk takes one entry
// per cycle unless the response stalls, over a table with one read and one write port.
// Reset is synchronous and empties the table; entry storage is not cleared.
// A stalled response holds the result register and stalls the emit pass and finish.
module association_pair_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_cmd,
   input  logic [15:0] req_index,
   input  logic [15:0] req_address_index,
   input  logic [15:0] req_group_object,
   input  logic [15:0] req_new_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_address_out,
   output logic [15:0] rsp_group_object_out,
   output logic [6:0]  rsp_match_count,
   output logic        rsp_hit,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import apt_pkg::*;

   apt_cmd_type  ctl;
   apt_stat_type stat;
   logic [15:0]  max_addr_ff, max_obj_ff;
   logic         csr_wr;

   // Configuration registers; writes land in the access phase.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_addr_ff <= 16'hFFFE;
         max_obj_ff <= 16'hFFFE;
      end else if (csr_wr && paddr[1:0] == 2'b00 && paddr[2] == REG_MAX_ADDR) begin
         max_addr_ff <= pwdata[15:0];
      end else if (csr_wr && paddr[1:0] == 2'b00 && paddr[2] == REG_MAX_OBJ) begin
         max_obj_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MAX_ADDR: prdata = {16'h0, max_addr_ff};
         REG_MAX_OBJ:  prdata = {16'h0, max_obj_ff};
         default:      prdata = '0;
      endcase
   end

   apt_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .ctl(ctl)
   );

   apt_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .stat(stat),
      .req_cmd(req_cmd), .req_index(req_index),
      .req_address_index(req_address_index), .req_group_object(req_group_object),
      .req_new_length(req_new_length),
      .max_addr(max_addr_ff), .max_obj(max_obj_ff),
      .rsp_status(rsp_status), .rsp_address_out(rsp_address_out),
      .rsp_group_object_out(rsp_group_object_out),
      .rsp_match_count(rsp_match_count), .rsp_hit(rsp_hit), .rsp_last(rsp_last)
   );

`ifndef SYNTHESIS
   a_ready_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
   a_cfg_hold: assert property (@(posedge clock) disable iff (reset)
      !(psel && penable && pwrite) |=> $stable(max_addr_ff))
      else $error("limit changed without write");
   a_pready: assert property (@(posedge clock) pready) else $error("pready low");
`endif

endmodule

// ===== rtl/apt_datapath.sv =====
module apt_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  apt_pkg::apt_cmd_type  ctl,
   output apt_pkg::apt_stat_type stat,
   input  logic [3:0]            req_cmd,
   input  logic [15:0]           req_index,
   input  logic [15:0]           req_address_index,
   input  logic [15:0]           req_group_object,
   input  logic [15:0]           req_new_length,
   input  logic [15:0]           max_addr,
   input  logic [15:0]           max_obj,
   output logic [1:0]            rsp_status,
   output logic [15:0]           rsp_address_out,
   output logic [15:0]           rsp_group_object_out,
   output logic [6:0]            rsp_match_count,
   output logic                  rsp_hit,
   output logic                  rsp_last
);
   import apt_pkg::*;

   logic [15:0] mem_a [MaxEntries];
   logic [15:0] mem_g [MaxEntries];

   logic [3:0]      cmd_ff;
   logic [15:0]     idx_ff, a_ff, g_ff, nl_ff;
   logic [LenW-1:0] len_ff, len_in;
   logic [LenW-1:0] rp_ff, wp_ff, cnt_ff, tot_ff;
   logic            rv_ff, hit_ff;
   logic [15:0]     rda_ff, rdg_ff;
   logic [1:0]      st_ff;
   logic [15:0]     oa_ff, og_ff;
   logic [6:0]      omc_ff;
   logic            ohit_ff, olast_ff;

   logic        by_obj, is_del, is_find, key_hit, pair_hit, valid_pair;
   logic        wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [IdxW-1:0] rd_addr;
   logic [15:0] wr_a, wr_g;
   logic [16:0] idx_ext;

   assign by_obj  = (cmd_ff == CMD_FIND_OBJ) || (cmd_ff == CMD_DEL_OBJ);
   assign is_del  = (cmd_ff == CMD_DEL_ADDR) || (cmd_ff == CMD_DEL_OBJ);
   assign is_find = (cmd_ff == CMD_FIND_ADDR) || (cmd_ff == CMD_FIND_OBJ);
   assign key_hit = by_obj ? (rdg_ff == g_ff) : (rda_ff == a_ff);
   assign pair_hit = (rda_ff == a_ff) && (rdg_ff == g_ff);
   assign valid_pair = (a_ff <= max_addr) && (g_ff <= max_obj);
   assign idx_ext = {1'b0, idx_ff};

   // Get rereads its own entry; every other walk follows the read pointer.
   assign rd_addr = (cmd_ff == CMD_GET) ? idx_ff[IdxW-1:0] : rp_ff[IdxW-1:0];

   assign stat.cmd = cmd_ff;
   assign stat.rd_done = (rp_ff == len_ff);
   assign stat.fill_done = ({{(17-LenW){1'b0}}, wp_ff} >= idx_ext)
      || (idx_ext >= 17'(MaxEntries));
   assign stat.match = rv_ff && key_hit;
   assign stat.matches_left = (cnt_ff != tot_ff);

   // Write port: compaction writes on scan, gap fill, and finish writes.
   always_comb begin
      wr_en = 1'b0;
      wr_addr = wp_ff[IdxW-1:0];
      wr_a = rda_ff;
      wr_g = rdg_ff;
      if (ctl.scan_step && rv_ff) begin
         if (cmd_ff == CMD_REMOVE_AT) begin
            wr_en = ({{(17-LenW){1'b0}}, rp_ff} > idx_ext + 17'd1);
            wr_addr = IdxW'(rp_ff - LenW'(2));
         end else if (is_del) begin
            wr_en = !key_hit;
         end
      end else if (ctl.fill_step) begin
         wr_en = 1'b1;
         wr_a = 16'hFFFF;
         wr_g = 16'hFFFF;
      end else if (ctl.finish) begin
         wr_addr = idx_ff[IdxW-1:0];
         wr_a = a_ff;
         wr_g = g_ff;
         case (cmd_ff)
            CMD_ADD: begin
               wr_addr = len_ff[IdxW-1:0];
               wr_en = valid_pair && (len_ff < LenW'(MaxEntries)) && !hit_ff;
            end
            CMD_SET: wr_en = valid_pair && (idx_ext < {{(17-LenW){1'b0}}, len_ff});
            CMD_SET_EXPAND: wr_en = (idx_ext < 17'(MaxEntries));
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= wr_a;
         mem_g[wr_addr] <= wr_g;
      end
      if (ctl.rd_issue) begin
         rda_ff <= mem_a[rd_addr];
         rdg_ff <= mem_g[rd_addr];
      end
   end

   always_comb begin
      len_in = len_ff;
      if (ctl.finish) begin
         case (cmd_ff)
            CMD_ADD:
               if (valid_pair && (len_ff < LenW'(MaxEntries)) && !hit_ff)
                  len_in = len_ff + LenW'(1);
            CMD_REMOVE_AT:
               if (idx_ext < {{(17-LenW){1'b0}}, len_ff}) len_in = len_ff - LenW'(1);
            CMD_SET_EXPAND:
               if (idx_ext < 17'(MaxEntries) && idx_ext >= {{(17-LenW){1'b0}}, len_ff})
                  len_in = LenW'(idx_ff) + LenW'(1);
            CMD_DEL_ADDR, CMD_DEL_OBJ: len_in = wp_ff;
            CMD_TRUNCATE:
               if ({1'b0, nl_ff} < {{(17-LenW){1'b0}}, len_ff}) len_in = LenW'(nl_ff);
            CMD_CLEAR: len_in = '0;
            default: len_in = len_ff;
         endcase
      end
   end

   // A read word stays pending until a scan step consumes it or a scan clear drops it.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         rv_ff <= !ctl.scan_clr && (ctl.rd_issue || (rv_ff && !ctl.scan_step));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_cmd;
         idx_ff <= req_index;
         a_ff <= req_address_index;
         g_ff <= req_group_object;
         nl_ff <= req_new_length;
      end
      if (ctl.load || ctl.scan_clr) begin
         rp_ff <= '0;
         wp_ff <= (cmd_ff == CMD_SET_EXPAND) ? len_ff : '0;
         cnt_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (ctl.rd_issue) rp_ff <= rp_ff + LenW'(1);
         if (ctl.fill_step) wp_ff <= wp_ff + LenW'(1);
         if (ctl.scan_step && rv_ff) begin
            if (is_del && !key_hit) begin
               wp_ff <= wp_ff + LenW'(1);
            end
            if ((cmd_ff == CMD_ADD || cmd_ff == CMD_HAS_PAIR) && pair_hit) hit_ff <= 1'b1;
            if ((is_find || is_del) && key_hit) cnt_ff <= cnt_ff + LenW'(1);
         end
      end
      if (ctl.load) tot_ff <= '0;
      else if (ctl.scan_clr && is_find) tot_ff <= cnt_ff;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (ctl.emit_find) begin
         st_ff <= ST_OK;
         oa_ff <= rda_ff;
         og_ff <= rdg_ff;
         omc_ff <= 7'(tot_ff);
         ohit_ff <= 1'b1;
         olast_ff <= (cnt_ff + LenW'(1) == tot_ff);
      end else if (ctl.finish) begin
         st_ff <= ST_OK;
         oa_ff <= '0;
         og_ff <= '0;
         omc_ff <= 7'(len_in);
         ohit_ff <= 1'b0;
         olast_ff <= 1'b1;
         case (cmd_ff)
            CMD_ADD: begin
               if (!valid_pair) st_ff <= ST_INVALID;
               else if (len_ff >= LenW'(MaxEntries)) st_ff <= ST_FULL;
               else ohit_ff <= hit_ff;
            end
            CMD_REMOVE_AT: begin
               if (idx_ext >= {{(17-LenW){1'b0}}, len_ff}) st_ff <= ST_INVALID;
               else ohit_ff <= 1'b1;
            end
            CMD_SET: begin
               if (idx_ext >= {{(17-LenW){1'b0}}, len_ff} || !valid_pair)
                  st_ff <= ST_INVALID;
               else ohit_ff <= 1'b1;
            end
            CMD_SET_EXPAND: begin
               if (idx_ext >= 17'(MaxEntries)) st_ff <= ST_INVALID;
               else ohit_ff <= 1'b1;
            end
            CMD_GET: begin
               if (idx_ext >= {{(17-LenW){1'b0}}, len_ff}) begin
                  oa_ff <= 16'hFFFF;
                  og_ff <= 16'hFFFF;
               end else begin
                  oa_ff <= rda_ff;
                  og_ff <= rdg_ff;
                  ohit_ff <= 1'b1;
               end
            end
            CMD_FIND_ADDR, CMD_FIND_OBJ: omc_ff <= '0;
            CMD_DEL_ADDR, CMD_DEL_OBJ: begin
               omc_ff <= 7'(cnt_ff);
               ohit_ff <= (cnt_ff != '0);
            end
            CMD_HAS_PAIR: begin
               oa_ff <= a_ff;
               og_ff <= g_ff;
               ohit_ff <= hit_ff;
            end
            CMD_TRUNCATE, CMD_CLEAR, CMD_SIZE: ;
            default: begin
               st_ff <= ST_INVALID;
               omc_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_status = st_ff;
   assign rsp_address_out = oa_ff;
   assign rsp_group_object_out = og_ff;
   assign rsp_match_count = omc_ff;
   assign rsp_hit = ohit_ff;
   assign rsp_last = olast_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LenW'(MaxEntries)) else $error("length above capacity");
   a_wp_le_rp: assert property (@(posedge clock) disable iff (reset)
      (is_del && ctl.scan_step) |-> wp_ff <= rp_ff)
      else $error("compaction write passed read");
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == CMD_ADD && ctl.finish) |=> (len_ff == $past(len_ff)
      || len_ff == $past(len_ff) + LenW'(1))) else $error("add grew length by more than one");
`endif

endmodule

// ===== rtl/apt_controller.sv =====
module apt_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  apt_pkg::apt_stat_type stat,
   output apt_pkg::apt_cmd_type  ctl
);
   import apt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_FILL   = 3'd2;
   localparam logic [2:0] S_FIN    = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;
   localparam logic [2:0] S_FSCAN  = 3'd5;
   localparam logic [2:0] S_START  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       ov_ff, ov_in;   // result register holds an unread word
   logic       pass2_ff, pass2_in;
   logic       out_free, is_find, needs_scan;

   assign out_free = !ov_ff || rsp_ready;
   assign is_find = (stat.cmd == CMD_FIND_ADDR) || (stat.cmd == CMD_FIND_OBJ);
   assign needs_scan = (stat.cmd == CMD_ADD) || (stat.cmd == CMD_REMOVE_AT)
      || is_find || (stat.cmd == CMD_DEL_ADDR) || (stat.cmd == CMD_DEL_OBJ)
      || (stat.cmd == CMD_HAS_PAIR) || (stat.cmd == CMD_GET);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = ov_ff;

   always_comb begin
      state_in = state_ff;
      pass2_in = pass2_ff;
      ctl = '0;
      ov_in = ov_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            ctl.scan_clr = 1'b1;
            pass2_in = 1'b0;
            if (stat.cmd == CMD_SET_EXPAND) state_in = S_FILL;
            else if (needs_scan) state_in = S_SCAN;
            else state_in = S_FIN;
         end
         S_FILL: begin
            if (stat.fill_done) state_in = S_FIN;
            else ctl.fill_step = 1'b1;
         end
         S_SCAN: begin
            // Every walk runs up to the length; get rereads its own entry.
            ctl.scan_step = 1'b1;
            if (!stat.rd_done) ctl.rd_issue = 1'b1;
            else state_in = S_FSCAN;
         end
         S_FSCAN: begin
            // The walk is over; a find goes on to its emit pass.
            ctl.scan_step = 1'b1;
            if (is_find && !pass2_ff) state_in = S_EMIT;
            else state_in = S_FIN;
         end
         S_EMIT: begin
            if (!pass2_ff) begin
               ctl.scan_clr = 1'b1;
               pass2_in = 1'b1;
               state_in = stat.matches_left ? S_EMIT : S_FIN;
            end else if (!stat.matches_left) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               // Walk to the next match, then emit it.
               ctl.scan_step = 1'b1;
               if (stat.match) begin
                  ctl.emit_find = 1'b1;
                  ov_in = 1'b1;
               end else if (!stat.rd_done) begin
                  ctl.rd_issue = 1'b1;
               end
               if (stat.match && !stat.rd_done) ctl.rd_issue = 1'b1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               ov_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         pass2_ff <= pass2_in;
      end
   end

`ifndef SYNTHESIS
   a_one_owner: assert property (@(posedge clock) disable iff (reset)
      !(ctl.finish && ctl.emit_find)) else $error("two result sources at once");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp_ready) |-> !(ctl.finish || ctl.emit_find))
      else $error("result word overwritten");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> state_ff == S_IDLE) else $error("load outside idle");
`endif

endmodule
